@@ rtl/pnz_pkg.sv @@
// Shared constants and types of the 2-D gradient noise sampler.
`default_nettype none

package pnz_pkg;

    localparam int unsigned GRID_SIZE     = 256;
    localparam int unsigned GRID_BITS     = $clog2(GRID_SIZE);
    localparam int unsigned FRACTION_BITS = 8;
    localparam int unsigned COORD_BITS    = 16;
    localparam int unsigned INDEX_BITS    = 16;
    localparam int unsigned Q_BITS        = 16;
    localparam int unsigned NUM_BANKS     = 4;
    localparam int unsigned BANK_DEPTH    = GRID_SIZE * GRID_SIZE / NUM_BANKS;
    localparam int unsigned BANK_ABITS    = $clog2(BANK_DEPTH);
    localparam int unsigned NUM_STAGES    = 9;

    typedef enum logic [1:0] {
        GRAD_POS_X = 2'd0,
        GRAD_NEG_X = 2'd1,
        GRAD_POS_Y = 2'd2,
        GRAD_NEG_Y = 2'd3
    } t_grad;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req;

    typedef logic [Q_BITS-1:0]        t_frac;
    typedef logic [Q_BITS:0]          t_fade;
    typedef logic signed [Q_BITS+1:0] t_corner;
    typedef logic [NUM_STAGES:1]      t_stage_en;

    typedef struct packed {
        logic                  en;
        logic [INDEX_BITS-1:0] index;
        t_grad                 code;
    } t_load;

    localparam t_fade FADE_ONE = t_fade'(1) << Q_BITS;

endpackage

`default_nettype wire

@@ rtl/perlin_noise_2d_sampler.sv @@
// Top level of the 2-D gradient noise sampler.
// Takes one item per clock while the output side keeps up. A load writes a 2-bit
// gradient code into the 256x256 table and gives no result; a sample gives one
// Q0.16 noise value. The table is held in four 16384x2 RAM banks split by row
// and column parity, so the four corners of a cell are read in the same cycle;
// a sample right after a load sees the new entry. The table is not cleared at
// reset: every entry a sample touches must have been loaded. Stalls on the
// output side hold only the full stages, bubbles are squeezed out.
`default_nettype none

module perlin_noise_2d_sampler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_req_type,
    input  wire logic [pnz_pkg::INDEX_BITS-1:0] i_grad_index,
    input  wire logic [1:0]                     i_grad_code,
    input  wire logic [pnz_pkg::COORD_BITS-1:0] i_x_coord,
    input  wire logic [pnz_pkg::COORD_BITS-1:0] i_y_coord,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [pnz_pkg::Q_BITS-1:0]          o_noise_value
);
    import pnz_pkg::*;

    t_stage_en en;
    t_stage_en r_vld;
    t_load     load;
    t_frac     tx, ty;
    t_fade     sx, sy;
    t_corner   c_tl, c_tr, c_bl, c_br;

    always_comb begin
        en[NUM_STAGES] = !r_vld[NUM_STAGES] || i_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid && (i_req_type == REQ_SAMPLE);
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready    = en[1];
    assign o_valid    = r_vld[NUM_STAGES];
    assign load.en    = i_valid && o_ready && (i_req_type == REQ_LOAD);
    assign load.index = i_grad_index;
    assign load.code  = t_grad'(i_grad_code);

    pnz_fetch u_fetch (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_load    (load),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_tx      (tx),
        .o_ty      (ty),
        .o_tl      (c_tl),
        .o_tr      (c_tr),
        .o_bl      (c_bl),
        .o_br      (c_br)
    );

    pnz_fade u_fade_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (tx),
        .o_s   (sx)
    );

    pnz_fade u_fade_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (ty),
        .o_s   (sy)
    );

    pnz_lerp u_lerp (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_tl          (c_tl),
        .i_tr          (c_tr),
        .i_bl          (c_bl),
        .i_br          (c_br),
        .i_sx          (sx),
        .i_sy          (sy),
        .o_noise_value (o_noise_value)
    );

endmodule

`default_nettype wire

@@ rtl/pnz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pnz_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/pnz_fetch.sv @@
// Banked gradient table, corner lookup and corner dot products (stages 1 and 2).
`default_nettype none

module pnz_fetch (
    input  wire logic                          i_clk,
    input  wire pnz_pkg::t_stage_en            i_en,
    input  wire pnz_pkg::t_load                i_load,
    input  wire logic [pnz_pkg::COORD_BITS-1:0] i_x_coord,
    input  wire logic [pnz_pkg::COORD_BITS-1:0] i_y_coord,
    output pnz_pkg::t_frac                     o_tx,
    output pnz_pkg::t_frac                     o_ty,
    output pnz_pkg::t_corner                   o_tl,
    output pnz_pkg::t_corner                   o_tr,
    output pnz_pkg::t_corner                   o_bl,
    output pnz_pkg::t_corner                   o_br
);
    import pnz_pkg::*;

    localparam t_corner CORNER_ONE = t_corner'(1) <<< Q_BITS;

    logic [GRID_BITS-1:0]     ix, iy, ix1, iy1, lrow, lcol;
    logic [BANK_ABITS-1:0]    waddr;
    logic [1:0]               rd [NUM_BANKS];
    logic                     r_px, r_py;
    logic [FRACTION_BITS-1:0] r_fx, r_fy;
    t_corner                  dx0, dx1, dy0, dy1;
    t_corner                  r_tl, r_tr, r_bl, r_br;

    function automatic t_corner f_dot(input logic [1:0] code, input t_corner dx,
                                      input t_corner dy);
        case (t_grad'(code))
            GRAD_POS_X: return dx;
            GRAD_NEG_X: return -dx;
            GRAD_POS_Y: return dy;
            default:    return -dy;
        endcase
    endfunction

    assign ix    = i_x_coord[FRACTION_BITS +: GRID_BITS];
    assign iy    = i_y_coord[FRACTION_BITS +: GRID_BITS];
    assign ix1   = GRID_BITS'(ix + 1'b1);
    assign iy1   = GRID_BITS'(iy + 1'b1);
    assign lrow  = i_load.index[GRID_BITS +: GRID_BITS];
    assign lcol  = i_load.index[GRID_BITS-1:0];
    assign waddr = {lrow[GRID_BITS-1:1], lcol[GRID_BITS-1:1]};

    // bank = {row parity, column parity}: the four corners always hit four banks
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [GRID_BITS-1:0]  cx, ry;
        logic [BANK_ABITS-1:0] raddr;
        logic                  we;

        assign cx    = (ix[0] == BANK_ID[0]) ? ix : ix1;
        assign ry    = (iy[0] == BANK_ID[1]) ? iy : iy1;
        assign raddr = {ry[GRID_BITS-1:1], cx[GRID_BITS-1:1]};
        assign we    = i_load.en && ({lrow[0], lcol[0]} == BANK_ID);

        pnz_ram #(
            .WIDTH (2),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (i_load.code),
            .i_re    (i_en[1]),
            .i_raddr (raddr),
            .o_rdata (rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_px <= ix[0];
            r_py <= iy[0];
            r_fx <= i_x_coord[FRACTION_BITS-1:0];
            r_fy <= i_y_coord[FRACTION_BITS-1:0];
        end
    end

    assign o_tx = t_frac'(r_fx) << (Q_BITS - FRACTION_BITS);
    assign o_ty = t_frac'(r_fy) << (Q_BITS - FRACTION_BITS);
    assign dx0  = t_corner'({2'b00, o_tx});
    assign dy0  = t_corner'({2'b00, o_ty});
    assign dx1  = dx0 - CORNER_ONE;
    assign dy1  = dy0 - CORNER_ONE;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_tl <= f_dot(rd[{r_py, r_px}], dx0, dy0);
            r_tr <= f_dot(rd[{r_py, !r_px}], dx1, dy0);
            r_bl <= f_dot(rd[{!r_py, r_px}], dx0, dy1);
            r_br <= f_dot(rd[{!r_py, !r_px}], dx1, dy1);
        end
    end

    assign o_tl = r_tl;
    assign o_tr = r_tr;
    assign o_bl = r_bl;
    assign o_br = r_br;

endmodule

`default_nettype wire

@@ rtl/pnz_fade.sv @@
// Pipelined quintic fade 6t^5-15t^4+10t^3 on a Q0.16 fraction (stages 2 to 5).
`default_nettype none

module pnz_fade (
    input  wire logic               i_clk,
    input  wire pnz_pkg::t_stage_en i_en,
    input  wire pnz_pkg::t_frac     i_t,
    output pnz_pkg::t_fade          o_s
);
    import pnz_pkg::*;

    localparam int unsigned PW = 2 * Q_BITS;
    localparam int unsigned QW = Q_BITS + 4;
    localparam int unsigned SW = Q_BITS + QW;
    localparam logic [QW:0] TEN_ONE = (QW + 1)'(10) << Q_BITS;

    t_frac             r2_t;
    logic [PW-1:0]     r2_tt;
    logic [PW-1:0]     r3_p;
    logic [QW-1:0]     r3_q;
    logic [SW-1:0]     r4_sp;
    t_fade             r5_s;
    logic [PW+2:0]     six_tt;
    logic [QW-1:0]     fifteen_t;
    logic [QW:0]       q_sum;
    logic [QW-1:0]     s_full;

    // q >> 16 = (6tt >> 16) + 10T - 15t, the other terms being multiples of T
    assign six_tt    = (PW + 3)'({r2_tt, 2'b00}) + (PW + 3)'({r2_tt, 1'b0});
    assign fifteen_t = QW'({r2_t, 4'b0000}) - QW'(r2_t);
    assign q_sum     = (QW + 1)'(six_tt[PW+2:Q_BITS]) + TEN_ONE - (QW + 1)'(fifteen_t);
    assign s_full    = r4_sp[SW-1:Q_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_t  <= i_t;
            r2_tt <= PW'(i_t) * PW'(i_t);
        end
        if (i_en[3]) begin
            r3_p <= PW'(r2_tt[PW-1:Q_BITS]) * PW'(r2_t);
            r3_q <= q_sum[QW-1:0];
        end
        if (i_en[4]) begin
            r4_sp <= SW'(r3_p[PW-1:Q_BITS]) * SW'(r3_q);
        end
        if (i_en[5]) begin
            r5_s <= (s_full > QW'(FADE_ONE)) ? FADE_ONE : s_full[Q_BITS:0];
        end
    end

    assign o_s = r5_s;

endmodule

`default_nettype wire

@@ rtl/pnz_lerp.sv @@
// Bilinear blend of the corner dot products and output scaling (stages 3 to 9).
`default_nettype none

module pnz_lerp (
    input  wire logic                   i_clk,
    input  wire pnz_pkg::t_stage_en     i_en,
    input  wire pnz_pkg::t_corner       i_tl,
    input  wire pnz_pkg::t_corner       i_tr,
    input  wire pnz_pkg::t_corner       i_bl,
    input  wire pnz_pkg::t_corner       i_br,
    input  wire pnz_pkg::t_fade         i_sx,
    input  wire pnz_pkg::t_fade         i_sy,
    output logic [pnz_pkg::Q_BITS-1:0]  o_noise_value
);
    import pnz_pkg::*;

    localparam int unsigned DW  = Q_BITS + 3;
    localparam int unsigned LW  = 2 * Q_BITS + 2;
    localparam int unsigned P1W = DW + Q_BITS + 2;
    localparam int unsigned RW  = LW + 1;
    localparam int unsigned P2W = RW + Q_BITS + 2;
    localparam int unsigned VW  = 3 * Q_BITS + 3;
    localparam logic signed [VW-1:0] BIAS = VW'(1) <<< (3 * Q_BITS);
    localparam logic [Q_BITS:0] OUT_MAX = {1'b0, {Q_BITS{1'b1}}};

    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [LW-1:0] t_lr;
    typedef logic signed [RW-1:0] t_rdiff;
    typedef logic signed [VW-1:0] t_v;

    t_corner            r3_tl, r3_tr, r4_tl, r4_tr, r5_tl, r5_tr;
    t_diff              r3_dl, r3_dr, r4_dl, r4_dr, r5_dl, r5_dr;
    t_lr                r6_left, r6_right, r7_left;
    t_rdiff             r7_diff;
    t_fade              r6_sx, r7_sx;
    t_v                 r8_v;
    logic [Q_BITS-1:0]  r9_noise;
    logic signed [P1W-1:0] left_full, right_full;
    logic signed [P2W-1:0] v_full;
    t_v                 biased;
    logic [Q_BITS:0]    scaled;

    // left = TL*(T-sy) + BL*sy = TL*T + (BL-TL)*sy
    assign left_full  = (P1W'(r5_tl) <<< Q_BITS)
                      + P1W'(r5_dl) * P1W'($signed({1'b0, i_sy}));
    assign right_full = (P1W'(r5_tr) <<< Q_BITS)
                      + P1W'(r5_dr) * P1W'($signed({1'b0, i_sy}));
    assign v_full     = (P2W'(r7_left) <<< Q_BITS)
                      + P2W'(r7_diff) * P2W'($signed({1'b0, r7_sx}));
    assign biased     = r8_v + BIAS;
    assign scaled     = biased[3*Q_BITS+1:2*Q_BITS+1];

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_tl <= i_tl;
            r3_tr <= i_tr;
            r3_dl <= t_diff'(i_bl) - t_diff'(i_tl);
            r3_dr <= t_diff'(i_br) - t_diff'(i_tr);
        end
        if (i_en[4]) begin
            r4_tl <= r3_tl;
            r4_tr <= r3_tr;
            r4_dl <= r3_dl;
            r4_dr <= r3_dr;
        end
        if (i_en[5]) begin
            r5_tl <= r4_tl;
            r5_tr <= r4_tr;
            r5_dl <= r4_dl;
            r5_dr <= r4_dr;
        end
        if (i_en[6]) begin
            r6_left  <= t_lr'(left_full);
            r6_right <= t_lr'(right_full);
            r6_sx    <= i_sx;
        end
        if (i_en[7]) begin
            r7_left <= r6_left;
            r7_diff <= t_rdiff'(r6_right) - t_rdiff'(r6_left);
            r7_sx   <= r6_sx;
        end
        if (i_en[8]) begin
            r8_v <= t_v'(v_full);
        end
        if (i_en[9]) begin
            if (biased[VW-1]) begin
                r9_noise <= '0;
            end else if (scaled > OUT_MAX) begin
                r9_noise <= OUT_MAX[Q_BITS-1:0];
            end else begin
                r9_noise <= scaled[Q_BITS-1:0];
            end
        end
    end

    assign o_noise_value = r9_noise;

endmodule

`default_nettype wire

@@ rtl/pnz_check.sv @@
// Port-level assertions for the noise sampler, bound to the top level.
`default_nettype none

module pnz_check (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_ready,
    input wire logic                           i_req_type,
    input wire logic                           o_valid,
    input wire logic                           i_ready,
    input wire logic [pnz_pkg::Q_BITS-1:0]     o_noise_value
);
    import pnz_pkg::*;

    logic sample_xfer;

    assign sample_xfer = i_valid && o_ready && (i_req_type == REQ_SAMPLE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending right after reset");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled while output side is free");

    // with the output side always ready, a sample transfer is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_xfer ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("sample result missing at full flow");

endmodule

bind perlin_noise_2d_sampler pnz_check u_pnz_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_noise_value (o_noise_value)
);

`default_nettype wire
